// File: hw/rtl/gmt_pkg.sv
package gmt_pkg;

    // Field widths of the stream payloads.
    localparam int LAT_W       = 31;
    localparam int LON_W       = 32;
    localparam int ZOOM_W      = 5;
    localparam int TILE_W      = 39;
    localparam int S_TDATA_W   = 72;
    localparam int M_TDATA_W   = 80;

    // Default configuration of the top level.
    localparam int MAX_ZOOM_DEF       = 22;
    localparam int TILE_FRAC_BITS_DEF = 16;

    // Zoom plus fraction bits never exceeds 54, so a 6-bit shift count suffices.
    localparam int SH_W = 6;

    // Fixed-point constants.
    localparam logic [63:0]  ONES64    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]  PI_Q60    = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0]  DEG_Q60   = PI_Q60 / 64'd180;
    localparam logic [63:0]  LN2_Q64   = 64'hB172_17F7_D1CF_79AB;
    localparam logic [63:0]  INVPI_Q64 = 64'h517C_C1B7_2722_0A94;
    localparam logic [127:0] COEF_PROD = {64'd0, LN2_Q64} * {64'd0, INVPI_Q64};
    localparam logic [63:0]  OFF_COEF  = 64'(COEF_PROD >> 66);
    localparam logic [63:0]  ONE_Q60   = 64'd1 << 60;
    localparam logic [63:0]  HALF_Q56  = 64'd1 << 55;
    localparam logic [56:0]  FULL_Q56  = 57'd1 << 56;

    localparam logic signed [LON_W-1:0] HALF_TURN = 32'sd1509949440;
    localparam logic [LAT_W-1:0]        POLE_MAG  = 31'd754974720;

    // Longitude scaling: 360 * 2^23 = 45 * 2^26.
    localparam int          LON_SHIFT   = 26;
    localparam logic [63:0] LON_DIV     = 64'd45;
    localparam logic [63:0] LON_RECIP   = ONES64 / 64'd45;

    // Sine series: divisors (2k)(2k+1) and their reciprocals in Q64.
    localparam int TERMS    = 12;
    localparam int LOG_BITS = 56;

    localparam logic [63:0] TAYLOR_DIV [TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    localparam logic [63:0] TAYLOR_RECIP [TERMS] = '{
        ONES64 / 64'd6,   ONES64 / 64'd20,  ONES64 / 64'd42,
        ONES64 / 64'd72,  ONES64 / 64'd110, ONES64 / 64'd156,
        ONES64 / 64'd210, ONES64 / 64'd272, ONES64 / 64'd342,
        ONES64 / 64'd420, ONES64 / 64'd506, ONES64 / 64'd600
    };

endpackage

// File: hw/rtl/geo_to_mercator_tile.sv
// Converts a latitude/longitude point at a given zoom into fractional Web Mercator
// tile coordinates. One point enters per cycle while the skid entry is empty, and
// every point yields exactly one result, in order. The latency is set by the row
// path: the sine series over twelve terms, then the two log2 units of 56 squaring
// steps each on a pipelined 64x64 multiplier. A two-entry output stage lets the
// block keep taking input while a result waits, until the skid entry fills. Latitudes
// at or beyond the Mercator limit give a row of 0 (north) or 2^zoom (south) with the
// clamp flag set; longitude is saturated to +/-180 degrees and zoom to MAX_ZOOM.
module geo_to_mercator_tile #(
    parameter int MAX_ZOOM       = gmt_pkg::MAX_ZOOM_DEF,
    parameter int TILE_FRAC_BITS = gmt_pkg::TILE_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // lat_fixed[30:0], lon_fixed[62:31], zoom_level[67:63], zero fill
    input  logic [gmt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tile_x[38:0], tile_y[77:39], zero fill
    output logic [gmt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // lat_clamped[0]
    output logic [0:0]                     m_axis_tuser
);

    localparam int TW       = gmt_pkg::TILE_W;
    localparam int TERMS    = gmt_pkg::TERMS;
    localparam int LOG_BITS = gmt_pkg::LOG_BITS;
    localparam int S_BLK    = 6;
    localparam int S_SUM    = S_BLK + 5 * TERMS + 1;
    localparam int S_V      = S_SUM + 1;
    localparam int S_N1     = S_V + 1;
    localparam int S_N2     = S_N1 + 1;
    localparam int S_R      = S_N2 + 2 * LOG_BITS + 1;
    localparam int S_D      = S_R + 1;
    localparam int S_OFF    = S_D + 2;
    localparam int LAT      = S_OFF + 1;

    typedef struct packed {
        logic                     north;
        logic                     pole;
        logic [gmt_pkg::SH_W-1:0] sh;
    } side_t;

    typedef struct packed {
        logic [TW-1:0] tile_y;
        logic [TW-1:0] tile_x;
        logic          clamped;
    } res_t;

    function automatic logic [5:0] lead_one(input logic [63:0] v);
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

    // One squaring step of the log2 unit: renormalize to [1,2) in Q62.
    function automatic logic [64:0] sq_norm(input logic [127:0] prod);
        logic [63:0] z;
        z = prod[125:62];
        if (z[63]) begin
            return {1'b1, 1'b0, z[63:1]};
        end
        return {1'b0, z};
    endfunction

    logic pipe_en;
    logic v_reg [1:LAT];

    // ------------------------------------------------------------------
    // Stage 1: unpack, magnitude, saturation.
    // ------------------------------------------------------------------
    logic signed [gmt_pkg::LAT_W-1:0]  in_lat;
    logic signed [gmt_pkg::LON_W-1:0]  in_lon;
    logic        [gmt_pkg::ZOOM_W-1:0] in_zoom;
    logic signed [gmt_pkg::LON_W-1:0]  lon_sat;
    logic signed [gmt_pkg::LON_W:0]    lon_sum;
    logic        [gmt_pkg::ZOOM_W-1:0] zoom_sat;
    logic        [gmt_pkg::LAT_W-1:0]  in_mag;
    side_t                             in_side;

    logic [gmt_pkg::LAT_W-1:0] mag1_reg;
    logic [gmt_pkg::LON_W-1:0] u1_reg;
    side_t                     side_reg [1:S_OFF];

    always_comb begin
        in_lat  = signed'(s_axis_tdata[30:0]);
        in_lon  = signed'(s_axis_tdata[62:31]);
        in_zoom = s_axis_tdata[67:63];
        in_mag  = in_lat[gmt_pkg::LAT_W-1] ? gmt_pkg::LAT_W'(-in_lat)
                                           : gmt_pkg::LAT_W'(in_lat);
        if (in_lon < -gmt_pkg::HALF_TURN) begin
            lon_sat = -gmt_pkg::HALF_TURN;
        end else if (in_lon > gmt_pkg::HALF_TURN) begin
            lon_sat = gmt_pkg::HALF_TURN;
        end else begin
            lon_sat = in_lon;
        end
        lon_sum  = 33'(lon_sat) + 33'(gmt_pkg::HALF_TURN);
        zoom_sat = (in_zoom > gmt_pkg::ZOOM_W'(MAX_ZOOM)) ? gmt_pkg::ZOOM_W'(MAX_ZOOM)
                                                          : in_zoom;
        in_side.north = !in_lat[gmt_pkg::LAT_W-1] && (in_lat != '0);
        in_side.pole  = (in_mag >= gmt_pkg::POLE_MAG);
        in_side.sh    = gmt_pkg::SH_W'(zoom_sat) + gmt_pkg::SH_W'(TILE_FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            mag1_reg    <= in_mag;
            u1_reg      <= lon_sum[gmt_pkg::LON_W-1:0];
            side_reg[1] <= in_side;
        end
    end

    for (genvar i = 2; i <= S_OFF; i++) begin : g_side
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[1] <= 1'b0;
        end else if (pipe_en) begin
            v_reg[1] <= s_axis_tvalid;
        end
    end

    for (genvar i = 2; i <= LAT; i++) begin : g_valid
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (pipe_en) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Column path: x = floor(((u << sh) >> 26) / 45).
    // ------------------------------------------------------------------
    logic [63:0]   w2_reg;
    logic [63:0]   w3_reg;
    logic [63:0]   w4_reg;
    logic [127:0]  x_prod;
    logic [63:0]   x_q0;
    logic [63:0]   x_rem;
    logic [TW-1:0] xs_reg [5:S_OFF];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            w2_reg <= 64'((96'(u1_reg) << side_reg[1].sh) >> gmt_pkg::LON_SHIFT);
            w3_reg <= w2_reg;
            w4_reg <= w3_reg;
        end
    end

    gmt_mul64 u_mul_x (
        .aclk (aclk),
        .en   (pipe_en),
        .a    (w2_reg),
        .b    (gmt_pkg::LON_RECIP),
        .p    (x_prod)
    );

    always_comb begin
        x_q0  = x_prod[127:64];
        x_rem = w4_reg - x_q0 * gmt_pkg::LON_DIV;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            xs_reg[5] <= (x_rem >= gmt_pkg::LON_DIV) ? TW'(x_q0 + 64'd1) : TW'(x_q0);
        end
    end

    for (genvar i = 6; i <= S_OFF; i++) begin : g_xs
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                xs_reg[i] <= xs_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle in Q60 radians and its square.
    // ------------------------------------------------------------------
    logic [127:0] phi_prod;
    logic [127:0] phi2_prod;
    logic [63:0]  phi4_reg;
    logic [63:0]  phi5_reg;

    gmt_mul64 u_mul_phi (
        .aclk (aclk),
        .en   (pipe_en),
        .a    ({33'd0, mag1_reg}),
        .b    (gmt_pkg::DEG_Q60),
        .p    (phi_prod)
    );

    gmt_mul64 u_mul_phi2 (
        .aclk (aclk),
        .en   (pipe_en),
        .a    (phi_prod[86:23]),
        .b    (phi_prod[86:23]),
        .p    (phi2_prod)
    );

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            phi4_reg <= phi_prod[86:23];
            phi5_reg <= phi4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sine series: one pipelined block per term.
    // ------------------------------------------------------------------
    logic [63:0]        blk_term [0:TERMS];
    logic signed [63:0] blk_s    [0:TERMS];
    logic [63:0]        blk_phi2 [0:TERMS];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            blk_term[0] <= phi5_reg;
            blk_s[0]    <= '0;
            blk_phi2[0] <= phi2_prod[123:60];
        end
    end

    for (genvar k = 0; k < TERMS; k++) begin : g_term
        logic [127:0]       prod_a;
        logic [127:0]       prod_b;
        logic signed [63:0] s_d  [4];
        logic [63:0]        ph_d [4];
        logic [63:0]        n_d  [2];
        logic [63:0]        q0;
        logic [63:0]        rem;

        gmt_mul64 u_mul_a (
            .aclk (aclk),
            .en   (pipe_en),
            .a    (blk_term[k]),
            .b    (blk_phi2[k]),
            .p    (prod_a)
        );

        gmt_mul64 u_mul_b (
            .aclk (aclk),
            .en   (pipe_en),
            .a    (prod_a[123:60]),
            .b    (gmt_pkg::TAYLOR_RECIP[k]),
            .p    (prod_b)
        );

        always_comb begin
            q0  = prod_b[127:64];
            rem = n_d[1] - q0 * gmt_pkg::TAYLOR_DIV[k];
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                // The previous term enters the sum here; odd-numbered terms subtract.
                if (k % 2 == 1) begin
                    s_d[0] <= blk_s[k] - signed'(blk_term[k]);
                end else begin
                    s_d[0] <= blk_s[k] + signed'(blk_term[k]);
                end
                ph_d[0] <= blk_phi2[k];
                for (int j = 1; j < 4; j++) begin
                    s_d[j]  <= s_d[j-1];
                    ph_d[j] <= ph_d[j-1];
                end
                n_d[0]        <= prod_a[123:60];
                n_d[1]        <= n_d[0];
                blk_s[k+1]    <= s_d[3];
                blk_phi2[k+1] <= ph_d[3];
                blk_term[k+1] <= (rem >= gmt_pkg::TAYLOR_DIV[k]) ? q0 + 64'd1 : q0;
            end
        end
    end

    logic signed [63:0] s_fin_reg;
    logic [63:0]        s_clip;
    logic               scl_reg [S_V:S_OFF];
    logic [63:0]        lv_reg  [2];
    logic [5:0]         lead_reg [2];
    logic [63:0]        lvn_reg [2];

    always_comb begin
        s_clip = s_fin_reg[63] ? 64'd0 : 64'(s_fin_reg);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            if (TERMS % 2 == 1) begin
                s_fin_reg <= blk_s[TERMS] - signed'(blk_term[TERMS]);
            end else begin
                s_fin_reg <= blk_s[TERMS] + signed'(blk_term[TERMS]);
            end
            scl_reg[S_V] <= (s_clip >= gmt_pkg::ONE_Q60);
            lv_reg[0]    <= gmt_pkg::ONE_Q60 + s_clip;
            lv_reg[1]    <= gmt_pkg::ONE_Q60 - s_clip;
        end
    end

    for (genvar i = S_V + 1; i <= S_OFF; i++) begin : g_scl
        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                scl_reg[i] <= scl_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Two log2 lanes: log2(1+s) and log2(1-s), result {int, 56 fraction bits}.
    // ------------------------------------------------------------------
    logic [63:0] lr_reg [2];

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
        logic [63:0]  z0_reg;
        logic [63:0]  r0_reg;
        logic [127:0] prod [LOG_BITS];
        logic [63:0]  zin  [LOG_BITS];
        logic [63:0]  rin  [LOG_BITS];
        logic [63:0]  rd   [LOG_BITS][2];
        logic [64:0]  last_norm;

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                lead_reg[ln] <= lead_one(lv_reg[ln]);
                lvn_reg[ln]  <= lv_reg[ln];
                if (lead_reg[ln] <= 6'd62) begin
                    z0_reg <= lvn_reg[ln] << (6'd62 - lead_reg[ln]);
                end else begin
                    z0_reg <= lvn_reg[ln] >> 1;
                end
                r0_reg <= {8'(lead_reg[ln]) - 8'd60, 56'd0};
            end
        end

        for (genvar j = 0; j < LOG_BITS; j++) begin : g_sq
            if (j == 0) begin : g_first
                assign zin[j] = z0_reg;
                assign rin[j] = r0_reg;
            end else begin : g_next
                logic [64:0] nrm;
                assign nrm    = sq_norm(prod[j-1]);
                assign zin[j] = nrm[63:0];
                assign rin[j] = rd[j-1][1] | (64'(nrm[64]) << (LOG_BITS - j));
            end

            gmt_mul64 u_mul_sq (
                .aclk (aclk),
                .en   (pipe_en),
                .a    (zin[j]),
                .b    (zin[j]),
                .p    (prod[j])
            );

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    rd[j][0] <= rin[j];
                    rd[j][1] <= rd[j][0];
                end
            end
        end

        assign last_norm = sq_norm(prod[LOG_BITS-1]);

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                lr_reg[ln] <= rd[LOG_BITS-1][1] | 64'(last_norm[64]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale the log difference to a world fraction and form the row.
    // ------------------------------------------------------------------
    logic [63:0]  d_reg;
    logic [127:0] off_prod;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d_reg <= lr_reg[0] - lr_reg[1];
        end
    end

    gmt_mul64 u_mul_off (
        .aclk (aclk),
        .en   (pipe_en),
        .a    (d_reg),
        .b    (gmt_pkg::OFF_COEF),
        .p    (off_prod)
    );

    logic [63:0] off;
    side_t       fin_side;
    logic [56:0] t_q56;
    res_t        fin_res;
    res_t        pipe_res_reg;

    always_comb begin
        off      = off_prod[127:64];
        fin_side = side_reg[S_OFF];
        fin_res.clamped = fin_side.pole || scl_reg[S_OFF] || (off > gmt_pkg::HALF_Q56);
        if (fin_res.clamped) begin
            t_q56 = fin_side.north ? 57'd0 : gmt_pkg::FULL_Q56;
        end else if (fin_side.north) begin
            t_q56 = 57'(gmt_pkg::HALF_Q56 - off);
        end else begin
            t_q56 = 57'(gmt_pkg::HALF_Q56 + off);
        end
        fin_res.tile_y = TW'(t_q56 >> (gmt_pkg::SH_W'(56) - fin_side.sh));
        fin_res.tile_x = xs_reg[S_OFF];
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pipe_res_reg <= fin_res;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid entry.
    // ------------------------------------------------------------------
    logic out_v_reg;
    logic sk_v_reg;
    res_t out_reg;
    res_t sk_reg;
    logic pipe_fire;
    logic out_free;

    assign pipe_en       = !sk_v_reg;
    assign pipe_fire     = pipe_en && v_reg[LAT];
    assign out_free      = !out_v_reg || m_axis_tready;
    assign s_axis_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end else if (out_free) begin
            if (sk_v_reg) begin
                out_v_reg <= 1'b1;
                sk_v_reg  <= 1'b0;
            end else begin
                out_v_reg <= pipe_fire;
            end
        end else if (pipe_fire) begin
            sk_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= sk_v_reg ? sk_reg : pipe_res_reg;
        end else if (pipe_fire) begin
            sk_reg <= pipe_res_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {2'b00, out_reg.tile_y, out_reg.tile_x};
    assign m_axis_tuser  = out_reg.clamped;

`ifndef SYNTHESIS
    // The skid entry only fills behind a waiting output transfer.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_v_reg |-> out_v_reg)
        else $error("skid entry valid while output register empty");

    // With the skid entry full, the pipeline stops taking input.
    a_skid_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        sk_v_reg |-> !s_axis_tready)
        else $error("input accepted while skid entry full");

    // A stalled output keeps the waiting result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && !m_axis_tready |=> out_v_reg && $stable(out_reg))
        else $error("waiting result changed under stall");

    // The column never exceeds the grid size at the largest zoom.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> ({25'd0, out_reg.tile_x} <= (64'd1 << (MAX_ZOOM + TILE_FRAC_BITS))))
        else $error("tile column beyond grid");
`endif

endmodule

// File: hw/rtl/gmt_mul64.sv
module gmt_mul64 (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);

    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [127:0] p_reg;

    // The first register stage forms the four 32x32 partial products, the second sums them.
    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg <= a[31:0]  * b[31:0];
            p01_reg <= a[31:0]  * b[63:32];
            p10_reg <= a[63:32] * b[31:0];
            p11_reg <= a[63:32] * b[63:32];
            p_reg   <= {p11_reg, 64'd0}
                     + ({64'd0, p01_reg} << 32)
                     + ({64'd0, p10_reg} << 32)
                     + {64'd0, p00_reg};
        end
    end

    assign p = p_reg;

endmodule
